### rtl/core/hnb_pkg.sv
// Shared types and constants for the height map normal baker.
// No dependencies; imported by every other file of the block but hnb_ram.
`timescale 1ns / 1ps
`default_nettype none

package hnb_pkg;

    localparam int SAMPLE_W   = 16;  // raw height sample
    localparam int SIZE_W     = 13;  // map_width / map_height registers
    localparam int WORLD_W    = 31;  // world size registers, unsigned Q15.16
    localparam int HGT_W      = 32;  // height_low / height_high, signed Q16.16
    localparam int CFG_DATA_W = 32;
    localparam int IDX_W      = 3;
    localparam int WORD_W     = 32;
    localparam int CH_W       = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [1:0]      ALPHA  = 2'd3;
    localparam logic [CH_W-1:0] CH_MID = 10'd511;   // channel value of a zero normal
    localparam logic [CH_W-1:0] CH_MAX = 10'd1023;

    typedef enum logic [IDX_W-1:0] {
        REG_MAP_WIDTH  = 3'd0,
        REG_MAP_HEIGHT = 3'd1,
        REG_WORLD_X    = 3'd2,
        REG_WORLD_Z    = 3'd3,
        REG_HEIGHT_LO  = 3'd4,
        REG_HEIGHT_HI  = 3'd5
    } t_reg_idx;

    // configuration as seen by the back end (sizes already clamped)
    typedef struct packed {
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
        logic [WORLD_W-1:0]      world_x;
        logic [WORLD_W-1:0]      world_z;
        logic signed [HGT_W-1:0] lo;
        logic signed [HGT_W-1:0] hi;
    } t_cfg;

    // one normal to compute: four neighbor samples plus flags
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_l;
        logic [SAMPLE_W-1:0] raw_r;
        logic [SAMPLE_W-1:0] raw_u;
        logic [SAMPLE_W-1:0] raw_d;
        logic                span_x2;   // left/right are two pixels apart
        logic                span_z2;   // up/down are two rows apart
        logic                frame_end;
        logic                last;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/hnb_ram.sv
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hnb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/hnb_front.sv
// Front end: config registers, raster counters, line store and window.
// Turns each sample into up to three normal jobs. Uses hnb_pkg, hnb_ram.
`timescale 1ns / 1ps
`default_nettype none

module hnb_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [hnb_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hnb_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [hnb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output hnb_pkg::t_cfg                    o_cfg,
    output logic                             o_job_valid,
    input  logic                             i_job_ready,
    output hnb_pkg::t_job                    o_job
);

    import hnb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + 1;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_READ  = 4'b0010,
        F_WRITE = 4'b0100,
        F_EMIT  = 4'b1000
    } t_fstate;

    t_fstate r_state;
    logic [2:0] r_cnt;

    logic [SIZE_W-1:0]       r_map_width, r_map_height;
    logic [WORLD_W-1:0]      r_world_x, r_world_z;
    logic signed [HGT_W-1:0] r_lo, r_hi;

    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [SAMPLE_W-1:0] r_win0, r_win1, r_win2;   // newest, middle, oldest
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_rd [4];                 // left, right, up, mid-of-prev

    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [31:0] w32, h32, x32, y32;
    logic last_col, last_row;
    logic [XW-1:0] xl, xr;
    logic cb, pb;
    logic [AW-1:0] rd_addr;
    logic [SAMPLE_W-1:0] rdata;
    logic has0, has1, has2, cur_has;
    logic restart;
    t_job job;

    always_comb begin
        if (r_map_width < SIZE_W'(2)) begin
            w_eff = SIZE_W'(2);
        end else if (32'(r_map_width) > MAX_WIDTH) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = r_map_width;
        end
        if (r_map_height < SIZE_W'(2)) begin
            h_eff = SIZE_W'(2);
        end else if (32'(r_map_height) > MAX_HEIGHT) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_map_height;
        end
    end

    assign w32 = 32'(w_eff);
    assign h32 = 32'(h_eff);
    assign x32 = 32'(r_x);
    assign y32 = 32'(r_y);
    assign last_col = (x32 + 32'd1 == w32);
    assign last_row = (y32 + 32'd1 == h32);
    assign xl = (r_x == '0) ? r_x : r_x - XW'(1);
    assign xr = last_col ? r_x : r_x + XW'(1);
    assign cb = r_y[0];
    assign pb = ~r_y[0];

    // a size write restarts the frame; it owns the counters and window that cycle
    assign restart = i_cfg_valid && ((i_cfg_index == REG_MAP_WIDTH)
                                  || (i_cfg_index == REG_MAP_HEIGHT));

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: rd_addr = {pb, xl};
            2'd1: rd_addr = {pb, xr};
            2'd2: rd_addr = {(y32 == 32'd1) ? pb : cb, r_x};
            2'd3: rd_addr = {pb, r_x};
        endcase
    end

    hnb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 << XW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_state == F_WRITE),
        .i_waddr ({cb, r_x}),
        .i_wdata (r_sample),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign has0 = (r_y != '0);
    assign has1 = last_row && (r_x != '0);
    assign has2 = last_row && last_col;

    // window is already updated when jobs go out: r_win0 is this sample
    always_comb begin
        job = '0;
        cur_has = 1'b0;
        unique case (r_cnt[1:0])
            2'd0: begin
                cur_has       = has0;
                job.raw_l     = r_rd[0];
                job.raw_r     = r_rd[1];
                job.raw_u     = r_rd[2];
                job.raw_d     = r_sample;
                job.span_x2   = (r_x != '0) && !last_col;
                job.span_z2   = (y32 != 32'd1);
                job.last      = !has1 && !has2;
            end
            2'd1: begin
                cur_has       = has1;
                job.raw_l     = (x32 == 32'd1) ? r_win1 : r_win2;
                job.raw_r     = r_win0;
                job.raw_u     = r_rd[0];
                job.raw_d     = r_win1;
                job.span_x2   = (x32 != 32'd1);
                job.last      = !has2;
            end
            2'd2: begin
                cur_has       = has2;
                job.raw_l     = r_win1;
                job.raw_r     = r_win0;
                job.raw_u     = r_rd[3];
                job.raw_d     = r_win0;
                job.frame_end = 1'b1;
                job.last      = 1'b1;
            end
            default: begin
                cur_has = 1'b0;
            end
        endcase
    end

    assign o_job       = job;
    assign o_job_valid = (r_state == F_EMIT) && cur_has;
    assign o_ready     = (r_state == F_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_cfg.width   = w_eff;
    assign o_cfg.height  = h_eff;
    assign o_cfg.world_x = r_world_x;
    assign o_cfg.world_z = r_world_z;
    assign o_cfg.lo      = r_lo;
    assign o_cfg.hi      = r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_cnt        <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_win0       <= '0;
            r_win1       <= '0;
            r_win2       <= '0;
            r_map_width  <= SIZE_W'(1024);
            r_map_height <= SIZE_W'(1024);
            r_world_x    <= WORLD_W'(65536);
            r_world_z    <= WORLD_W'(65536);
            r_lo         <= '0;
            r_hi         <= HGT_W'(65536);
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample;
                        r_cnt    <= '0;
                        r_state  <= F_READ;
                    end
                end
                F_READ: begin
                    if (r_cnt != '0) begin
                        r_rd[r_cnt[1:0] - 2'd1] <= rdata;
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= F_WRITE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                F_WRITE: begin
                    if (!restart) begin
                        r_win2 <= r_win1;
                        r_win1 <= r_win0;
                        r_win0 <= r_sample;
                    end
                    r_cnt   <= '0;
                    r_state <= F_EMIT;
                end
                F_EMIT: begin
                    if (!cur_has || i_job_ready) begin
                        if (r_cnt[1:0] == 2'd2) begin
                            r_state <= F_IDLE;
                            if (!restart) begin
                                if (last_col) begin
                                    r_x <= '0;
                                    r_y <= last_row ? '0 : r_y + YW'(1);
                                end else begin
                                    r_x <= r_x + XW'(1);
                                end
                            end
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase

            if (i_cfg_valid) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_MAP_WIDTH: begin
                        r_map_width <= i_cfg_data[SIZE_W-1:0];
                        r_x <= '0;
                        r_y <= '0;
                        r_win0 <= '0;
                        r_win1 <= '0;
                        r_win2 <= '0;
                    end
                    REG_MAP_HEIGHT: begin
                        r_map_height <= i_cfg_data[SIZE_W-1:0];
                        r_x <= '0;
                        r_y <= '0;
                        r_win0 <= '0;
                        r_win1 <= '0;
                        r_win2 <= '0;
                    end
                    REG_WORLD_X:   r_world_x <= i_cfg_data[WORLD_W-1:0];
                    REG_WORLD_Z:   r_world_z <= i_cfg_data[WORLD_W-1:0];
                    REG_HEIGHT_LO: r_lo <= i_cfg_data;
                    REG_HEIGHT_HI: r_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/hnb_queue.sv
// Small job queue between front and back end.
// Uses hnb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  hnb_pkg::t_job i_push,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output hnb_pkg::t_job o_pop
);

    import hnb_pkg::*;

    t_job r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW:0] r_wptr, r_rptr;
    logic full, empty;

    assign empty = (r_wptr == r_rptr);
    assign full  = (r_wptr[QUEUE_AW] != r_rptr[QUEUE_AW])
                && (r_wptr[QUEUE_AW-1:0] == r_rptr[QUEUE_AW-1:0]);
    assign o_push_ready = !full;
    assign o_pop_valid  = !empty;
    assign o_pop        = r_slot[r_rptr[QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push_valid && !full) begin
            r_slot[r_wptr[QUEUE_AW-1:0]] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push_valid && !full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop_ready && !empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/hnb_back.sv
// Back end: serial arithmetic that turns one job into a packed normal.
// Uses hnb_pkg; holds the output register of the block.
`timescale 1ns / 1ps
`default_nettype none

module hnb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hnb_pkg::t_cfg                i_cfg,
    input  logic                         i_job_valid,
    output logic                         o_job_ready,
    input  hnb_pkg::t_job                i_job,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [hnb_pkg::WORD_W-1:0]   o_tdata,
    output logic                         o_tlast,
    output logic                         o_tuser
);

    import hnb_pkg::*;

    localparam int HQ_W  = 34;   // floor(raw * range / 65536)
    localparam int MAG_W = 62;   // products of the cross vector
    localparam int LEN_W = 33;
    localparam int REM_W = 44;

    typedef enum logic [9:0] {
        B_IDLE = 10'b00_0000_0001,
        B_HMUL = 10'b00_0000_0010,
        B_DIV  = 10'b00_0000_0100,
        B_MUL  = 10'b00_0000_1000,
        B_NORM = 10'b00_0001_0000,
        B_SQ   = 10'b00_0010_0000,
        B_SQRT = 10'b00_0100_0000,
        B_CHI  = 10'b00_1000_0000,
        B_CH   = 10'b01_0000_0000,
        B_OUT  = 10'b10_0000_0000
    } t_bstate;

    t_bstate r_state;
    logic [5:0] r_cnt;
    t_job r_job;

    logic signed [HQ_W-1:0] r_hq [4];
    logic signed [31:0] r_d, r_a;
    logic [31:0] r_cq, r_bq;
    logic [SIZE_W-1:0] r_crem, r_brem;
    logic [MAG_W-1:0] r_mx, r_my, r_mz, r_prod;
    logic [63:0] r_acc, r_root;
    logic [62:0] r_bit;
    logic [REM_W-1:0] r_rem [3];
    logic [REM_W-1:0] r_dsh;
    logic [CH_W:0] r_q [3];

    logic r_tvalid, r_tlast, r_tuser;
    logic [WORD_W-1:0] r_tdata;

    // height products
    logic [SAMPLE_W-1:0] h_raw;
    logic signed [HGT_W:0] h_range;
    logic signed [SAMPLE_W:0] h_raw_s;
    logic signed [49:0] h_prod;
    logic signed [HQ_W:0] d_diff, a_diff;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: h_raw = r_job.raw_l;
            2'd1: h_raw = r_job.raw_r;
            2'd2: h_raw = r_job.raw_u;
            2'd3: h_raw = r_job.raw_d;
        endcase
    end

    assign h_range = $signed({i_cfg.hi[HGT_W-1], i_cfg.hi})
                   - $signed({i_cfg.lo[HGT_W-1], i_cfg.lo});
    assign h_raw_s = $signed({1'b0, h_raw});
    assign h_prod  = h_raw_s * h_range;
    assign d_diff  = $signed({r_hq[1][HQ_W-1], r_hq[1]}) - $signed({r_hq[0][HQ_W-1], r_hq[0]});
    assign a_diff  = $signed({r_hq[3][HQ_W-1], r_hq[3]}) - $signed({r_hq[2][HQ_W-1], r_hq[2]});

    // restoring dividers for the two grid spacings
    logic [SIZE_W:0] c_t, b_t, c_sub, b_sub;
    logic c_ge, b_ge;
    assign c_t   = {r_crem, r_cq[31]};
    assign b_t   = {r_brem, r_bq[31]};
    assign c_ge  = (c_t >= {1'b0, i_cfg.width});
    assign b_ge  = (b_t >= {1'b0, i_cfg.height});
    assign c_sub = c_t - {1'b0, i_cfg.width};
    assign b_sub = b_t - {1'b0, i_cfg.height};

    // shared 32x32 multiplier
    logic [31:0] mag_d, mag_a, mul_a, mul_b;
    logic [63:0] mul_p;
    assign mag_d = r_d[31] ? 32'(-r_d) : 32'(r_d);
    assign mag_a = r_a[31] ? 32'(-r_a) : 32'(r_a);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (r_state == B_MUL) begin
            unique case (r_cnt[1:0])
                2'd0:    begin mul_a = r_bq;  mul_b = mag_d; end
                2'd1:    begin mul_a = r_bq;  mul_b = r_cq;  end
                default: begin mul_a = mag_a; mul_b = r_cq;  end
            endcase
        end else if (r_state == B_SQ) begin
            unique case (r_cnt[1:0])
                2'd0:    mul_a = r_mx[31:0];
                2'd1:    mul_a = r_my[31:0];
                default: mul_a = r_mz[31:0];
            endcase
            mul_b = mul_a;
        end
    end
    assign mul_p = mul_a * mul_b;

    logic norm_busy;
    assign norm_busy = |{r_mx[MAG_W-1:31], r_my[MAG_W-1:31], r_mz[MAG_W-1:31]};

    logic [63:0] sq_sum;
    logic sq_ge;
    assign sq_sum = r_root + {1'b0, r_bit};
    assign sq_ge  = (r_acc >= sq_sum);

    // channel lanes: 0 red (x), 1 green (y), 2 blue (z)
    logic [LEN_W-1:0] len;
    logic [30:0] ch_mag [3];
    logic ch_neg [3];
    logic [LEN_W-1:0] ch_magc [3];
    logic [LEN_W:0] ch_num [3];
    logic [REM_W-1:0] ch_rem0 [3];
    logic ch_ge [3];
    logic [CH_W-1:0] ch_val [3];

    assign len       = r_root[LEN_W-1:0];
    assign ch_mag[0] = r_mx[30:0];
    assign ch_mag[1] = r_my[30:0];
    assign ch_mag[2] = r_mz[30:0];
    assign ch_neg[0] = !r_d[31] && (r_d != '0);
    assign ch_neg[1] = 1'b0;
    assign ch_neg[2] = !r_a[31] && (r_a != '0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ch_magc[k] = ({2'b0, ch_mag[k]} > len) ? len : {2'b0, ch_mag[k]};
            ch_num[k]  = ch_neg[k] ? ({1'b0, len} - {1'b0, ch_magc[k]})
                                   : ({1'b0, len} + {1'b0, ch_magc[k]});
            ch_rem0[k] = {ch_num[k], 10'b0} - {10'b0, ch_num[k]};
            ch_ge[k]   = (r_rem[k] >= r_dsh);
            ch_val[k]  = r_q[k][CH_W] ? CH_MAX : r_q[k][CH_W-1:0];
        end
    end

    logic out_free;
    assign out_free    = !r_tvalid || i_tready;
    assign o_job_ready = (r_state == B_IDLE);
    assign o_tvalid    = r_tvalid;
    assign o_tdata     = r_tdata;
    assign o_tlast     = r_tlast;
    assign o_tuser     = r_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_tvalid <= 1'b0;
        end else begin
            // B_OUT reloads the output register itself
            if (r_tvalid && i_tready && (r_state != B_OUT)) begin
                r_tvalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_cq    <= i_job.span_x2 ? {i_cfg.world_x, 1'b0} : {1'b0, i_cfg.world_x};
                        r_bq    <= i_job.span_z2 ? {i_cfg.world_z, 1'b0} : {1'b0, i_cfg.world_z};
                        r_crem  <= '0;
                        r_brem  <= '0;
                        r_cnt   <= '0;
                        r_state <= B_HMUL;
                    end
                end
                B_HMUL: begin
                    r_hq[r_cnt[1:0]] <= h_prod[49:16];
                    if (r_cnt == 6'd3) begin
                        r_cnt   <= '0;
                        r_state <= B_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_DIV: begin
                    r_d    <= sat32(d_diff);
                    r_a    <= sat32(a_diff);
                    r_crem <= c_ge ? c_sub[SIZE_W-1:0] : c_t[SIZE_W-1:0];
                    r_brem <= b_ge ? b_sub[SIZE_W-1:0] : b_t[SIZE_W-1:0];
                    r_cq   <= {r_cq[30:0], c_ge};
                    r_bq   <= {r_bq[30:0], b_ge};
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_state <= B_MUL;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_MUL: begin
                    unique case (r_cnt[1:0])
                        2'd0:    r_mx <= mul_p[MAG_W-1:0];
                        2'd1:    r_my <= mul_p[MAG_W-1:0];
                        default: r_mz <= mul_p[MAG_W-1:0];
                    endcase
                    if (r_cnt == 6'd2) begin
                        r_state <= B_NORM;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_NORM: begin
                    // common right shift until every component fits 31 bits
                    if (norm_busy) begin
                        r_mx <= r_mx >> 1;
                        r_my <= r_my >> 1;
                        r_mz <= r_mz >> 1;
                    end else begin
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    r_prod <= mul_p[MAG_W-1:0];
                    if (r_cnt != '0) begin
                        r_acc <= r_acc + {2'b0, r_prod};
                    end
                    if (r_cnt == 6'd3) begin
                        r_root  <= '0;
                        r_bit   <= {1'b1, 62'b0};
                        r_cnt   <= '0;
                        r_state <= B_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_SQRT: begin
                    if (sq_ge) begin
                        r_acc  <= r_acc - sq_sum;
                        r_root <= (r_root >> 1) + {1'b0, r_bit};
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 6'd31) begin
                        r_state <= B_CHI;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_CHI: begin
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k] <= ch_rem0[k];
                        r_q[k]   <= '0;
                    end
                    r_dsh   <= {1'b0, len, 10'b0};
                    r_cnt   <= '0;
                    r_state <= B_CH;
                end
                B_CH: begin
                    // divisor 2*len starts at weight 2^9: ten quotient bits
                    for (int k = 0; k < 3; k++) begin
                        if (ch_ge[k]) begin
                            r_rem[k] <= r_rem[k] - r_dsh;
                        end
                        r_q[k] <= {r_q[k][CH_W-1:0], ch_ge[k]};
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == 6'd9) begin
                        r_state <= B_OUT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_tvalid <= 1'b1;
                        r_tlast  <= r_job.last;
                        r_tuser  <= r_job.frame_end;
                        if (len == '0) begin
                            r_tdata <= {ALPHA, CH_MID, CH_MID, CH_MID};
                        end else begin
                            r_tdata <= {ALPHA, ch_val[2], ch_val[1], ch_val[0]};
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/heightmap_normal_bake.sv
// Height map to normal map baker. Raw 16-bit heights enter in raster order
// on the slave stream; packed R10G10B10A2 normals (alpha 3) leave on the
// master stream. Each pixel's normal comes from central differences of its
// left/right and up/down neighbors (an edge uses the pixel itself), heights
// scaled as lo + raw*(hi-lo)/65536 and spacings as world size over map size.
// Results trail the input by one row: a sample of row y>=1 yields the normal
// of the pixel above it, and the samples of the last row also flush that
// row, up to three results per sample. tlast marks the last result of a
// sample, tuser marks the final pixel of the frame. Writing map_width or
// map_height restarts the frame; write registers only while the block is
// idle. The front end takes one sample at a time through accept, five line
// store reads, window update and three job slots, held longer while the job
// queue is full; the back end takes one job at a time and runs it through
// its serial spacing divider (32 steps), the normalizing shift (0 to 31
// steps), the square root (32 steps) and the channel dividers (10 steps).
// A four-entry job queue lets the front end run ahead of the back end.
// The line store is two rows deep and needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_normal_bake #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // height samples
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] height_sample
    // normals
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [31:0] normal_word
    output logic                           m_axis_tlast,   // last_of_run
    output logic                           m_axis_tuser,   // [0] frame_end
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hnb_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [hnb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import hnb_pkg::*;

    t_cfg cfg;
    t_job f_job, q_job;
    logic f_job_valid, f_job_ready;
    logic q_job_valid, q_job_ready;

    // front: counters, line store, window, job generation
    hnb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_job_valid (f_job_valid),
        .i_job_ready (f_job_ready),
        .o_job       (f_job)
    );

    hnb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_job_valid),
        .o_push_ready (f_job_ready),
        .i_push       (f_job),
        .o_pop_valid  (q_job_valid),
        .i_pop_ready  (q_job_ready),
        .o_pop        (q_job)
    );

    // back: arithmetic and output register
    hnb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_job_valid),
        .o_job_ready (q_job_ready),
        .i_job       (q_job),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

    // the frame's final pixel is always the last result of its sample
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_end without last_of_run");

    // a sample is worked on before the next is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("bad state after reset");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking bench for heightmap_normal_bake: raster height streams in,
// packed normals out, checked against an in-bench fixed-point predictor.
// Depends on hnb_pkg and the heightmap_normal_bake RTL.
`timescale 1ns / 1ps

module tb;
    import hnb_pkg::*;

    localparam int MAXW        = 4096;
    localparam int MAXH        = 4096;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 400;     // no-result samples may still be in flight
    localparam int RAND_ITEMS  = 100;
    localparam logic [IDX_W-1:0] BAD_IDX = 3'd7;
    // flat surface, default spacing: straight up
    localparam logic [31:0] NRM_UP   = 32'hDFFF_FDFF;
    // flat surface, x spacing truncated to zero: degenerate normal
    localparam logic [31:0] NRM_ZERO = 32'hDFF7_FDFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    heightmap_normal_bake u_dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef struct {
        logic [31:0] word;
        logic        frame_end;
        logic        last;
    } t_normal;

    typedef struct {
        logic [15:0] sample;
        bit          typed;     // expected word is given below
        logic [31:0] word;
    } t_row;

    t_normal normals_due[$];
    int mismatches = 0;
    int normals_seen = 0;
    int samples_sent = 0;
    int frames_seen = 0;
    longint unsigned cycles = 0;

    // ---------------- predictor state ----------------
    logic [12:0]     p_width = 13'd1024, p_height = 13'd1024;
    longint unsigned p_wx = 65536, p_wz = 65536;
    longint          p_lo = 0, p_hi = 65536;
    logic [15:0]     p_rows [0:2*MAXW-1];
    logic [47:0]     p_window = '0;
    int unsigned     p_col = 0, p_row = 0;

    initial foreach (p_rows[k]) p_rows[k] = '0;

    function automatic int unsigned clamp_size(logic [12:0] v, int unsigned maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint scaled_height(logic [15:0] raw);
        longint span;
        span = p_hi - p_lo;
        return p_lo + ((longint'({16'd0, raw}) * span) >>> 16);  // floor
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic logic [9:0] to_channel(bit neg, longint unsigned mag,
                                              longint unsigned len);
        longint unsigned num, v;
        if (len == 0) return CH_MID;
        if (mag > len) mag = len;
        num = neg ? len - mag : len + mag;
        v = (1023 * num) / (2 * len);
        return (v > 1023) ? CH_MAX : v[9:0];
    endfunction

    function automatic logic [31:0] normal_of(logic [15:0] rl, rr, ru, rd,
                                              int unsigned sx, sz);
        longint unsigned c, b, mx, my, mz, m, len;
        longint d, a;
        int s;
        c = (longint'(sx) * p_wx) / clamp_size(p_width, MAXW);
        b = (longint'(sz) * p_wz) / clamp_size(p_height, MAXH);
        d = clip32(scaled_height(rr) - scaled_height(rl));
        a = clip32(scaled_height(rd) - scaled_height(ru));
        mx = b * ((d < 0) ? -d : d);
        my = b * c;
        mz = ((a < 0) ? -a : a) * c;
        m = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        s = 0;
        while ((m >> s) >= (64'd1 << 31)) s++;
        mx >>= s; my >>= s; mz >>= s;
        len = sqrt_floor(mx * mx + my * my + mz * mz);
        return {ALPHA, to_channel(a > 0, mz, len), to_channel(1'b0, my, len),
                to_channel(d > 0, mx, len)};
    endfunction

    function automatic void push_normal(logic [31:0] w, logic fe);
        t_normal n;
        n.word = w; n.frame_end = fe; n.last = 1'b0;
        normals_due.push_back(n);
    endfunction

    // Advances the predictor by one sample and queues the normals it releases.
    // typed: replace the computed words by the given one.
    function automatic void predict_sample(logic [15:0] smp, bit typed, logic [31:0] tw);
        int unsigned w, h, x, y, cb, pb, xl, xr, p, base;
        logic [15:0] up, newest, mid, old, left;
        w = clamp_size(p_width, MAXW);
        h = clamp_size(p_height, MAXH);
        x = (p_col >= w) ? w - 1 : p_col;
        y = (p_row >= h) ? h - 1 : p_row;
        cb = (y & 1) * MAXW;
        pb = ((y + 1) & 1) * MAXW;
        base = normals_due.size();
        if (y >= 1) begin
            xl = (x == 0) ? x : x - 1;
            xr = (x + 1 < w) ? x + 1 : x;
            up = (y == 1) ? p_rows[pb + x] : p_rows[cb + x];
            push_normal(typed ? tw : normal_of(p_rows[pb + xl], p_rows[pb + xr], up, smp,
                        xr - xl, (y == 1) ? 1 : 2), 1'b0);
        end
        p_rows[cb + x] = smp;
        p_window = {p_window[31:0], smp};
        if (y == h - 1) begin
            newest = p_window[15:0];
            mid    = p_window[31:16];
            old    = p_window[47:32];
            // last row: flush the pixel to the left, and the corner at row end
            if (x >= 1) begin
                p = x - 1;
                left = (p == 0) ? mid : old;
                push_normal(typed ? tw : normal_of(left, newest, p_rows[pb + p], mid,
                            (p == 0) ? 1 : 2, 1), 1'b0);
            end
            if (x == w - 1)
                push_normal(typed ? tw : normal_of(mid, newest, p_rows[pb + x], newest,
                            1, 1), 1'b1);
        end
        if (normals_due.size() > base) normals_due[$].last = 1'b1;
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        p_col = x;
        p_row = y;
    endfunction

    function automatic void predict_write(logic [IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            REG_MAP_WIDTH:  begin p_width = v[12:0]; p_col = 0; p_row = 0; p_window = '0; end
            REG_MAP_HEIGHT: begin p_height = v[12:0]; p_col = 0; p_row = 0; p_window = '0; end
            REG_WORLD_X:    p_wx = v[30:0];
            REG_WORLD_Z:    p_wz = v[30:0];
            REG_HEIGHT_LO:  p_lo = longint'($signed(v));
            REG_HEIGHT_HI:  p_hi = longint'($signed(v));
            default: ;  // unknown index ignored
        endcase
    endfunction

    // ---------------- output side: stall pattern and checking ----------------
    always @(posedge i_clk) begin
        t_normal exp_n;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d normals outstanding",
                     cycles, normals_due.size());
            $display("heightmap_normal_bake regression: fail");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            normals_seen++;
            if (m_axis_tuser) frames_seen++;
            if (normals_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal %h tlast=%b tuser=%b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                exp_n = normals_due.pop_front();
                if (m_axis_tdata !== exp_n.word || m_axis_tlast !== exp_n.last
                        || m_axis_tuser !== exp_n.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("normal #%0d: exp %h l=%b u=%b, got %h l=%b u=%b",
                                 normals_seen, exp_n.word, exp_n.last, exp_n.frame_end,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
        // stall mode, from cycles[10:9]: always ready, coin flip, mostly stalled, always ready
        case (cycles[10:9])
            2'd0, 2'd3: m_axis_tready <= 1'b1;
            2'd1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:    m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------- input side ----------------
    int burst_left = 0;

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        predict_write(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    // block idle: all normals out, plus time for samples that make none
    task automatic wait_idle();
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] smp, bit typed, logic [31:0] tw);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(posedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_sample(smp, typed, tw);
        samples_sent++;
        // drop tvalid after the transaction; the next call raises it again
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic configure(int unsigned w, h, logic [30:0] wx, wz, logic [31:0] lo, hi);
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_WORLD_X, {1'b0, wx});
        write_reg(REG_WORLD_Z, {1'b0, wz});
        write_reg(REG_HEIGHT_LO, lo);
        write_reg(REG_HEIGHT_HI, hi);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000 + 16'($urandom_range(0, 63));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [30:0] pick_world();
        case ($urandom_range(0, 5))
            0:       return 31'd1;
            1:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(1, 32'h0010_0000));
        endcase
    endfunction

    function automatic logic [31:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'hFFFF_FFFF);
        endcase
    endfunction

    t_row directed [$];

    initial begin
        int rand_done, n, w, h;
        bit paused;
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // 3x2 flat frame, x spacing 1/3 truncates to zero: all channels mid
        configure(3, 2, 31'd1, 31'd65536, 32'd0, 32'd65536);
        write_reg(BAD_IDX, 32'hFFFF_FFFF);   // unknown index must be ignored
        repeat (6) directed.push_back('{16'h8000, 1'b1, NRM_ZERO});
        foreach (directed[k]) send_sample(directed[k].sample, directed[k].typed, directed[k].word);
        wait_idle();

        // 3x3 flat frame at default spacing: normal straight up
        configure(3, 3, 31'd65536, 31'd65536, 32'd0, 32'd65536);
        directed.delete();
        repeat (9) directed.push_back('{16'h1234, 1'b1, NRM_UP});
        foreach (directed[k]) send_sample(directed[k].sample, directed[k].typed, directed[k].word);
        wait_idle();

        // undersized frame (clamped to 2x2), extreme spacings and height range
        configure(0, 1, 31'h7FFF_FFFF, 31'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        directed.delete();
        directed.push_back('{16'h0000, 1'b0, '0});
        directed.push_back('{16'hFFFF, 1'b0, '0});
        directed.push_back('{16'hFFFF, 1'b0, '0});
        directed.push_back('{16'h0000, 1'b0, '0});
        // second frame, inverted range
        directed.push_back('{16'hFFFF, 1'b0, '0});
        directed.push_back('{16'h0000, 1'b0, '0});
        directed.push_back('{16'h0001, 1'b0, '0});
        directed.push_back('{16'hFFFE, 1'b0, '0});
        for (int k = 0; k < 4; k++) send_sample(directed[k].sample, 1'b0, '0);
        wait_idle();
        write_reg(REG_HEIGHT_LO, 32'h7FFF_FFFF);
        write_reg(REG_HEIGHT_HI, 32'h8000_0000);
        for (int k = 4; k < 8; k++) send_sample(directed[k].sample, 1'b0, '0);
        wait_idle();

        // oversized frame (clamped to 4096): five first-row samples, no normals
        configure(8191, 8191, 31'd65536, 31'd65536, 32'd0, 32'd65536);
        repeat (5) send_sample(pick_sample(), 1'b0, '0);
        wait_idle();

        // random frames, mostly complete ones at small sizes
        rand_done = 0;
        while (rand_done < RAND_ITEMS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 5);
            h = $urandom_range(2, 4);
            configure(w, h, pick_world(), pick_world(), pick_height(), pick_height());
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w);   // partial frame
            for (int k = 0; k < n; k++) begin
                send_sample(pick_sample(), 1'b0, '0);
                rand_done++;
                // hold off once until the output side has fully caught up
                if (!paused && rand_done > RAND_ITEMS / 2) begin
                    paused = 1'b1;
                    while (normals_due.size() != 0) @(posedge i_clk);
                end
            end
            wait_idle();
        end

        $display("%0d samples sent, %0d normals checked, %0d frame ends, %0d mismatches",
                 samples_sent, normals_seen, frames_seen, mismatches);
        $display("covered flat, clamped-size, extreme-range and random frames");
        if (mismatches == 0 && normals_due.size() == 0) begin
            $display("heightmap_normal_bake regression: pass");
        end else begin
            $display("heightmap_normal_bake regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/hnb_pkg.sv
rtl/core/hnb_ram.sv
rtl/core/hnb_front.sv
rtl/core/hnb_queue.sv
rtl/core/hnb_back.sv
rtl/core/heightmap_normal_bake.sv
verif/tb.sv
